// ----- hdl/mhpq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhpq_pkg: shared definitions of the min-heap priority queue
// Request and status codes, the heap entry type, the sequencer states and
// the default capacity.
// ----------------------------------------------------------------------------
package mhpq_pkg;

	localparam int CAPACITY_DEFAULT = 16;

	localparam logic [1:0] REQ_INSERT  = 2'd0;
	localparam logic [1:0] REQ_EXTRACT = 2'd1;
	localparam logic [1:0] REQ_UPDATE  = 2'd2;

	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_FULL      = 2'd1;
	localparam logic [1:0] STATUS_EMPTY     = 2'd2;
	localparam logic [1:0] STATUS_NOT_FOUND = 2'd3;

	localparam logic signed [31:0] TIME_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] TIME_MIN = 32'sh8000_0000;

	typedef struct packed {
		logic [15:0]        number;
		logic signed [31:0] tval;
	} heap_entry_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_EXT_RD,
		ST_SRCH,
		ST_UP_RD,
		ST_UP_CMP,
		ST_DN_RD,
		ST_DN_CMP,
		ST_FIN
	} state_t;

endpackage

// ----- hdl/mhpq_req_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhpq_req_if: request channel of the min-heap priority queue
// Valid/ready channel that carries one request per transaction.
// ----------------------------------------------------------------------------
interface mhpq_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         req_type;
	logic [15:0]        task_number;
	logic signed [31:0] time_value;

	modport source(output valid, req_type, task_number, time_value, input ready);
	modport sink(input valid, req_type, task_number, time_value, output ready);
endinterface

// ----- hdl/mhpq_rsp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhpq_rsp_if: response channel of the min-heap priority queue
// Valid/ready channel that carries one result per transaction.
// ----------------------------------------------------------------------------
interface mhpq_rsp_if;
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic [15:0]        out_number;
	logic signed [31:0] out_time;
	logic [2:0]         out_level;
	logic [4:0]         entry_total;

	modport source(output valid, status, out_number, out_time, out_level, entry_total,
		input ready);
	modport sink(input valid, status, out_number, out_time, out_level, entry_total,
		output ready);
endinterface

// ----- hdl/mhpq_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhpq_ram: heap entry storage
// One write port and two read ports with registered read data.
// ----------------------------------------------------------------------------
module mhpq_ram #(
	parameter int DEPTH  = mhpq_pkg::CAPACITY_DEFAULT,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic                 clk,
	input  logic                 wr_en,
	input  logic [ADDR_W-1:0]    wr_addr,
	input  mhpq_pkg::heap_entry_t wr_data,
	input  logic [ADDR_W-1:0]    rda_addr,
	input  logic [ADDR_W-1:0]    rdb_addr,
	output mhpq_pkg::heap_entry_t rda_data,
	output mhpq_pkg::heap_entry_t rdb_data
);

	mhpq_pkg::heap_entry_t mem [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rda_data <= mem[rda_addr];
		rdb_data <= mem[rdb_addr];
	end

endmodule

// ----- hdl/min_heap_priority_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_heap_priority_queue: bounded binary min-heap of (task, time) entries
// Insert, extract-minimum and update-by-task-number on a heap held in RAM.
// ----------------------------------------------------------------------------
// One request is handled at a time by a small sequencer around a heap RAM
// with one write port and two registered read ports; each sift level takes
// a read state and a compare/write state. An update first finds its entry
// with a search that scans one held entry per cycle. A full insert, an empty
// extract and an unknown code go from dispatch straight to the finish state,
// and an update that finds no match scans every held entry first. The next
// request is taken while a result waits on the response channel; a result
// that stays blocked holds the sequencer in its last state.
module min_heap_priority_queue #(
	parameter int CAPACITY = mhpq_pkg::CAPACITY_DEFAULT
) (
	input logic        clk,
	input logic        arst_n,
	mhpq_req_if.sink   req,
	mhpq_rsp_if.source rsp
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int LVL_W = $clog2(CNT_W);

	mhpq_pkg::state_t state_q, state_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [IDX_W-1:0] cur_q, cur_d;
	mhpq_pkg::heap_entry_t item_q, item_d;
	logic up_only_q, up_only_d;
	logic [CNT_W-1:0] scan_q, scan_d;
	logic pend_q, pend_d;
	logic [1:0] req_q;
	logic [15:0] num_q;
	logic signed [31:0] tv_q;
	logic [1:0] res_status_q, res_status_d;
	logic [15:0] res_num_q, res_num_d;
	logic signed [31:0] res_time_q, res_time_d;

	logic rsp_valid_q;
	logic [1:0] rsp_status_q;
	logic [15:0] rsp_num_q;
	logic signed [31:0] rsp_time_q;
	logic [2:0] rsp_level_q;
	logic [4:0] rsp_total_q;

	logic accept;
	logic out_load;
	logic wr_en;
	logic [IDX_W-1:0] wr_addr, rda_addr, rdb_addr;
	mhpq_pkg::heap_entry_t wr_data, rda_data, rdb_data;

	logic [CNT_W:0] child_l, child_r;
	logic [IDX_W-1:0] parent_idx;
	logic [CNT_W-1:0] last_idx, hit_idx, pos1;
	logic [LVL_W-1:0] lvl_cur;
	logic signed [32:0] sum_ext;
	logic signed [31:0] sum_sat;
	logic pick_r;
	mhpq_pkg::heap_entry_t child_e;
	logic [IDX_W-1:0] child_idx;

	mhpq_ram #(
		.DEPTH (CAPACITY),
		.ADDR_W(IDX_W)
	) u_mhpq_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rda_addr(rda_addr),
		.rdb_addr(rdb_addr),
		.rda_data(rda_data),
		.rdb_data(rdb_data)
	);

	assign req.ready = (state_q == mhpq_pkg::ST_IDLE);
	assign accept    = req.valid && req.ready;

	assign child_l    = (CNT_W + 1)'({cur_q, 1'b1});
	assign child_r    = child_l + 1'b1;
	assign parent_idx = (cur_q - 1'b1) >> 1;
	assign last_idx   = count_q - 1'b1;
	assign hit_idx    = scan_q - 1'b1;
	assign pos1       = CNT_W'(cur_q) + 1'b1;

	assign sum_ext = {rda_data.tval[31], rda_data.tval} + {tv_q[31], tv_q};
	always_comb begin
		if (sum_ext[32] != sum_ext[31]) begin
			sum_sat = sum_ext[32] ? mhpq_pkg::TIME_MIN : mhpq_pkg::TIME_MAX;
		end else begin
			sum_sat = sum_ext[31:0];
		end
	end

	always_comb begin
		lvl_cur = '0;
		for (int b = 0; b < CNT_W; b++) begin
			if (pos1[b]) begin
				lvl_cur = LVL_W'(b);
			end
		end
	end

	assign pick_r    = (child_r < {1'b0, count_q}) &&
		($signed(rda_data.tval) > $signed(rdb_data.tval));
	assign child_e   = pick_r ? rdb_data : rda_data;
	assign child_idx = pick_r ? child_r[IDX_W-1:0] : child_l[IDX_W-1:0];

	always_comb begin
		state_d      = state_q;
		count_d      = count_q;
		cur_d        = cur_q;
		item_d       = item_q;
		up_only_d    = up_only_q;
		scan_d       = scan_q;
		pend_d       = pend_q;
		res_status_d = res_status_q;
		res_num_d    = res_num_q;
		res_time_d   = res_time_q;
		wr_en        = 1'b0;
		wr_addr      = cur_q;
		wr_data      = item_q;
		rda_addr     = '0;
		rdb_addr     = '0;
		out_load     = 1'b0;

		case (state_q)
			mhpq_pkg::ST_IDLE: begin
				if (accept) begin
					res_status_d = mhpq_pkg::STATUS_OK;
					res_num_d    = '0;
					res_time_d   = '0;
					state_d      = mhpq_pkg::ST_DISPATCH;
				end
			end
			mhpq_pkg::ST_DISPATCH: begin
				case (req_q)
					mhpq_pkg::REQ_INSERT: begin
						if (count_q >= CNT_W'(CAPACITY)) begin
							res_status_d = mhpq_pkg::STATUS_FULL;
							state_d      = mhpq_pkg::ST_FIN;
						end else begin
							cur_d       = count_q[IDX_W-1:0];
							item_d      = '{number: num_q, tval: tv_q};
							count_d     = count_q + 1'b1;
							up_only_d   = 1'b1;
							state_d     = mhpq_pkg::ST_UP_RD;
						end
					end
					mhpq_pkg::REQ_EXTRACT: begin
						if (count_q == '0) begin
							res_status_d = mhpq_pkg::STATUS_EMPTY;
							state_d      = mhpq_pkg::ST_FIN;
						end else begin
							rda_addr = '0;
							rdb_addr = last_idx[IDX_W-1:0];
							state_d  = mhpq_pkg::ST_EXT_RD;
						end
					end
					mhpq_pkg::REQ_UPDATE: begin
						scan_d  = '0;
						pend_d  = 1'b0;
						state_d = mhpq_pkg::ST_SRCH;
					end
					default: begin
						state_d = mhpq_pkg::ST_FIN;
					end
				endcase
			end
			mhpq_pkg::ST_EXT_RD: begin
				res_num_d  = rda_data.number;
				res_time_d = rda_data.tval;
				item_d     = rdb_data;
				count_d    = count_q - 1'b1;
				cur_d      = '0;
				state_d    = mhpq_pkg::ST_DN_RD;
			end
			mhpq_pkg::ST_SRCH: begin
				rda_addr = scan_q[IDX_W-1:0];
				if (pend_q && (rda_data.number == num_q)) begin
					item_d    = '{number: rda_data.number, tval: sum_sat};
					cur_d     = hit_idx[IDX_W-1:0];
					up_only_d = 1'b0;
					if (hit_idx == '0) begin
						state_d = mhpq_pkg::ST_DN_RD;
					end else begin
						state_d = mhpq_pkg::ST_UP_RD;
					end
				end else if (scan_q >= count_q) begin
					res_status_d = mhpq_pkg::STATUS_NOT_FOUND;
					state_d      = mhpq_pkg::ST_FIN;
				end else begin
					pend_d = 1'b1;
					scan_d = scan_q + 1'b1;
				end
			end
			mhpq_pkg::ST_UP_RD: begin
				if (cur_q == '0) begin
					wr_en   = 1'b1;
					state_d = mhpq_pkg::ST_FIN;
				end else begin
					rda_addr = parent_idx;
					state_d  = mhpq_pkg::ST_UP_CMP;
				end
			end
			mhpq_pkg::ST_UP_CMP: begin
				if ($signed(item_q.tval) < $signed(rda_data.tval)) begin
					wr_en     = 1'b1;
					wr_data   = rda_data;
					cur_d     = parent_idx;
					up_only_d = 1'b1;
					state_d   = mhpq_pkg::ST_UP_RD;
				end else if (!up_only_q) begin
					state_d = mhpq_pkg::ST_DN_RD;
				end else begin
					wr_en   = 1'b1;
					state_d = mhpq_pkg::ST_FIN;
				end
			end
			mhpq_pkg::ST_DN_RD: begin
				if (child_l >= {1'b0, count_q}) begin
					wr_en   = 1'b1;
					state_d = mhpq_pkg::ST_FIN;
				end else begin
					rda_addr = child_l[IDX_W-1:0];
					rdb_addr = child_r[IDX_W-1:0];
					state_d  = mhpq_pkg::ST_DN_CMP;
				end
			end
			mhpq_pkg::ST_DN_CMP: begin
				if ($signed(child_e.tval) < $signed(item_q.tval)) begin
					wr_en   = 1'b1;
					wr_data = child_e;
					cur_d   = child_idx;
					state_d = mhpq_pkg::ST_DN_RD;
				end else begin
					wr_en   = 1'b1;
					state_d = mhpq_pkg::ST_FIN;
				end
			end
			mhpq_pkg::ST_FIN: begin
				if (!rsp_valid_q || rsp.ready) begin
					out_load = 1'b1;
					state_d  = mhpq_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = mhpq_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mhpq_pkg::ST_IDLE;
			count_q     <= '0;
			up_only_q   <= 1'b0;
			pend_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			count_q   <= count_d;
			up_only_q <= up_only_d;
			pend_q    <= pend_d;
			if (out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		cur_q        <= cur_d;
		item_q       <= item_d;
		scan_q       <= scan_d;
		res_status_q <= res_status_d;
		res_num_q    <= res_num_d;
		res_time_q   <= res_time_d;
		if (accept) begin
			req_q <= req.req_type;
			num_q <= req.task_number;
			tv_q  <= req.time_value;
		end
		if (out_load) begin
			rsp_status_q <= res_status_q;
			rsp_total_q  <= 5'(count_q);
			if ((req_q == mhpq_pkg::REQ_UPDATE) && (res_status_q == mhpq_pkg::STATUS_OK)) begin
				rsp_num_q   <= item_q.number;
				rsp_time_q  <= item_q.tval;
				rsp_level_q <= 3'(lvl_cur);
			end else begin
				rsp_num_q   <= res_num_q;
				rsp_time_q  <= res_time_q;
				rsp_level_q <= '0;
			end
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = rsp_status_q;
	assign rsp.out_number  = rsp_num_q;
	assign rsp.out_time    = rsp_time_q;
	assign rsp.out_level   = rsp_level_q;
	assign rsp.entry_total = rsp_total_q;

endmodule

// ----- hdl/mhpq_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhpq_checker: port-level checks of the min-heap priority queue
// Watches both channels and flags results that contradict the heap state.
// ----------------------------------------------------------------------------
module mhpq_checker #(
	parameter int CAPACITY = mhpq_pkg::CAPACITY_DEFAULT
) (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [1:0]  status,
	input logic [15:0] out_number,
	input logic [31:0] out_time,
	input logic [2:0]  out_level,
	input logic [4:0]  entry_total
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) &&
		$stable(out_number) && $stable(out_time) && $stable(out_level) &&
		$stable(entry_total))
	else $error("Stalled response transaction changed.");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
	else $error("Request taken while the previous one was still in work.");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status == mhpq_pkg::STATUS_FULL) |->
		(entry_total == 5'(CAPACITY)) && (out_number == '0) && (out_level == '0))
	else $error("Full status reported with a count below capacity.");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status == mhpq_pkg::STATUS_EMPTY) |->
		(entry_total == '0) && (out_number == '0) && (out_time == '0))
	else $error("Empty status reported while entries remain.");

endmodule

bind min_heap_priority_queue mhpq_checker #(
	.CAPACITY(CAPACITY)
) u_mhpq_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.status     (rsp.status),
	.out_number (rsp.out_number),
	.out_time   (rsp.out_time),
	.out_level  (rsp.out_level),
	.entry_total(rsp.entry_total)
);

// ----- tb/tb_min_heap_priority_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_min_heap_priority_queue: self-checking testbench of the min-heap queue
// A clocked driver sends insert, extract-minimum, update and unused requests
// from a queue of pending transactions. A behavioral heap predicts every
// response. A clocked monitor compares each response field by field with the
// oldest prediction. Both channels idle at random, and the response side
// holds off once for a long stretch so that the block stalls its input.
// ----------------------------------------------------------------------------
module tb_min_heap_priority_queue;

	localparam int CAPACITY = mhpq_pkg::CAPACITY_DEFAULT;
	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS = 1250;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_AFTER = 600;
	localparam int HOLD_CYCLES = 400;

	typedef struct packed {
		logic [1:0]         kind;
		logic [15:0]        number;
		logic signed [31:0] tval;
	} request_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [15:0]        number;
		logic signed [31:0] tval;
		logic [2:0]         level;
		logic [4:0]         total;
	} response_t;

	logic clk;
	logic arst_n;

	mhpq_req_if req_ch();
	mhpq_rsp_if rsp_ch();

	min_heap_priority_queue #(.CAPACITY(CAPACITY)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	request_t  pending_requests[$];
	response_t expected_responses[$];

	logic [15:0]        heap_num [CAPACITY];
	logic signed [31:0] heap_time [CAPACITY];
	int heap_fill = 0;

	int error_count = 0;
	int accepted_count = 0;
	int response_count = 0;
	int cycle_count = 0;
	int hold_left = 0;
	logic hold_done = 1'b0;
	logic calm;

	assign calm = (cycle_count >= 3000) && (cycle_count < 8000);

	task automatic report_error(string msg);
		$display("ERROR at response %0d: %s", response_count, msg);
		error_count++;
	endtask

	function automatic void swap_slots(int a, int b);
		logic [15:0]        n;
		logic signed [31:0] t;
		n = heap_num[a];
		t = heap_time[a];
		heap_num[a] = heap_num[b];
		heap_time[a] = heap_time[b];
		heap_num[b] = n;
		heap_time[b] = t;
	endfunction

	function automatic int bubble_up(int start);
		int i;
		i = start;
		while (i > 0 && heap_time[i] < heap_time[(i - 1) / 2]) begin
			swap_slots(i, (i - 1) / 2);
			i = (i - 1) / 2;
		end
		return i;
	endfunction

	function automatic int bubble_down(int start);
		int i;
		int c;
		logic moving;
		i = start;
		moving = 1'b1;
		while (moving) begin
			c = 2 * i + 1;
			if (c >= heap_fill) begin
				moving = 1'b0;
			end else begin
				if (c + 1 < heap_fill && heap_time[c] > heap_time[c + 1])
					c++;
				if (heap_time[c] < heap_time[i]) begin
					swap_slots(c, i);
					i = c;
				end else begin
					moving = 1'b0;
				end
			end
		end
		return i;
	endfunction

	function automatic response_t apply_request(logic [1:0] kind, logic [15:0] number,
			logic signed [31:0] tval);
		response_t r;
		int idx;
		int walk;
		longint sum;
		r = '0;
		if (kind == mhpq_pkg::REQ_INSERT) begin
			if (heap_fill >= CAPACITY) begin
				r.status = mhpq_pkg::STATUS_FULL;
			end else begin
				heap_num[heap_fill] = number;
				heap_time[heap_fill] = tval;
				heap_fill++;
				void'(bubble_up(heap_fill - 1));
			end
		end else if (kind == mhpq_pkg::REQ_EXTRACT) begin
			if (heap_fill == 0) begin
				r.status = mhpq_pkg::STATUS_EMPTY;
			end else begin
				r.number = heap_num[0];
				r.tval = heap_time[0];
				heap_fill--;
				heap_num[0] = heap_num[heap_fill];
				heap_time[0] = heap_time[heap_fill];
				void'(bubble_down(0));
			end
		end else if (kind == mhpq_pkg::REQ_UPDATE) begin
			idx = 0;
			while (idx < heap_fill && heap_num[idx] != number)
				idx++;
			if (idx == heap_fill) begin
				r.status = mhpq_pkg::STATUS_NOT_FOUND;
			end else begin
				sum = longint'(heap_time[idx]) + longint'(tval);
				if (sum > longint'(mhpq_pkg::TIME_MAX))
					sum = longint'(mhpq_pkg::TIME_MAX);
				else if (sum < longint'(mhpq_pkg::TIME_MIN))
					sum = longint'(mhpq_pkg::TIME_MIN);
				heap_time[idx] = sum[31:0];
				if (idx > 0 && heap_time[idx] < heap_time[(idx - 1) / 2])
					idx = bubble_up(idx);
				else
					idx = bubble_down(idx);
				r.number = heap_num[idx];
				r.tval = heap_time[idx];
				walk = idx;
				while (walk != 0) begin
					walk = (walk - 1) / 2;
					r.level++;
				end
			end
		end
		r.total = 5'(heap_fill);
		return r;
	endfunction

	task automatic queue_request(logic [1:0] kind, logic [15:0] number,
			logic signed [31:0] tval);
		request_t item;
		item.kind = kind;
		item.number = number;
		item.tval = tval;
		pending_requests.push_back(item);
	endtask

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("min_heap_priority_queue test failed");
			$finish;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		request_t next_item;
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.req_type <= mhpq_pkg::REQ_INSERT;
			req_ch.task_number <= '0;
			req_ch.time_value <= '0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				accepted_count <= accepted_count + 1;
				expected_responses.push_back(apply_request(req_ch.req_type,
					req_ch.task_number, req_ch.time_value));
			end
			if (!req_ch.valid || req_ch.ready) begin
				if (pending_requests.size() != 0 && (calm || $urandom_range(99) >= 10)) begin
					next_item = pending_requests.pop_front();
					req_ch.valid <= 1'b1;
					req_ch.req_type <= next_item.kind;
					req_ch.task_number <= next_item.number;
					req_ch.time_value <= next_item.tval;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && response_count >= HOLD_AFTER) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		response_t want;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				response_count <= response_count + 1;
				if (expected_responses.size() == 0) begin
					report_error("response with no outstanding request");
				end else begin
					want = expected_responses.pop_front();
					if (rsp_ch.status !== want.status)
						report_error($sformatf("status got %0d expected %0d",
							rsp_ch.status, want.status));
					if (rsp_ch.out_number !== want.number)
						report_error($sformatf("out_number got %h expected %h",
							rsp_ch.out_number, want.number));
					if (rsp_ch.out_time !== want.tval)
						report_error($sformatf("out_time got %h expected %h",
							rsp_ch.out_time, want.tval));
					if (rsp_ch.out_level !== want.level)
						report_error($sformatf("out_level got %0d expected %0d",
							rsp_ch.out_level, want.level));
					if (rsp_ch.entry_total !== want.total)
						report_error($sformatf("entry_total got %0d expected %0d",
							rsp_ch.entry_total, want.total));
				end
			end
			rsp_ch.ready <= (hold_left == 0) && (calm || $urandom_range(99) >= 10);
		end
	end

	initial begin
		int i;
		int n;
		int mode;
		int roll;
		int sel;
		int ins_lim;
		int ext_lim;
		int request_total;
		logic [1:0]         kind;
		logic [15:0]        num;
		logic signed [31:0] tv;

		arst_n = 1'b0;

		queue_request(mhpq_pkg::REQ_EXTRACT, 16'h0000, 32'sd0);
		queue_request(mhpq_pkg::REQ_UPDATE, 16'h0005, 32'sd1);
		queue_request(REQ_UNUSED, 16'hFFFF, mhpq_pkg::TIME_MIN);
		queue_request(mhpq_pkg::REQ_INSERT, 16'hFFFF, mhpq_pkg::TIME_MAX);
		queue_request(mhpq_pkg::REQ_INSERT, 16'h0000, mhpq_pkg::TIME_MIN);
		queue_request(mhpq_pkg::REQ_INSERT, 16'h1234, 32'sd0);
		queue_request(mhpq_pkg::REQ_INSERT, 16'h0007, 32'sd0);
		queue_request(mhpq_pkg::REQ_UPDATE, 16'hFFFF, 32'sh0001_0000);
		queue_request(mhpq_pkg::REQ_UPDATE, 16'h0000, mhpq_pkg::TIME_MIN);
		queue_request(mhpq_pkg::REQ_UPDATE, 16'h1234, mhpq_pkg::TIME_MAX);
		queue_request(mhpq_pkg::REQ_UPDATE, 16'h0007, -32'sh0005_0000);
		queue_request(mhpq_pkg::REQ_UPDATE, 16'hAAAA, 32'sd0);
		for (i = 0; i < 12; i++)
			queue_request(mhpq_pkg::REQ_INSERT, 16'(16'h0100 + i),
				(i % 3) * 32'sh0001_0000);
		queue_request(mhpq_pkg::REQ_INSERT, 16'h5555, 32'sd0);
		queue_request(REQ_UNUSED, 16'h0000, mhpq_pkg::TIME_MAX);

		mode = 0;
		ins_lim = 60;
		ext_lim = 80;
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 40 == 0) begin
				mode = $urandom_range(2);
				case (mode)
					0: begin
						ins_lim = 60;
						ext_lim = 80;
					end
					1: begin
						ins_lim = 20;
						ext_lim = 75;
					end
					default: begin
						ins_lim = 35;
						ext_lim = 62;
					end
				endcase
			end
			roll = $urandom_range(99);
			if (roll < ins_lim)
				kind = mhpq_pkg::REQ_INSERT;
			else if (roll < ext_lim)
				kind = mhpq_pkg::REQ_EXTRACT;
			else if (roll < 98)
				kind = mhpq_pkg::REQ_UPDATE;
			else
				kind = REQ_UNUSED;
			num = ($urandom_range(3) != 0) ? 16'($urandom_range(15)) : 16'($urandom_range(65535));
			sel = $urandom_range(9);
			if (sel < 4)
				tv = ($urandom_range(16) - 8) << 16;
			else if (sel < 8)
				tv = $urandom;
			else if (sel == 8)
				tv = mhpq_pkg::TIME_MAX - $urandom_range(3);
			else
				tv = mhpq_pkg::TIME_MIN + $urandom_range(3);
			queue_request(kind, num, tv);
		end
		request_total = pending_requests.size();

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (accepted_count < request_total)
			@(negedge clk);
		while (expected_responses.size() != 0)
			@(negedge clk);
		repeat (60) @(negedge clk);
		if (expected_responses.size() != 0)
			report_error("responses still outstanding at the end");
		if (error_count == 0)
			$display("min_heap_priority_queue test passed");
		else
			$display("min_heap_priority_queue test failed");
		$finish;
	end

endmodule
